// ===== hw/rtl/sdspi_pkg.sv =====
// Shared types and constants for the SD card SPI-mode command transactor.
// Used by sdspi_fsm and sd_spi_command_transactor; depends on nothing.
package sdspi_pkg;

    localparam logic       OP_START    = 1'b0;
    localparam logic       OP_EXCHANGE = 1'b1;

    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_SEND_OP    = 6'd1;
    localparam logic [5:0] CMD_SEND_IF    = 6'd8;
    localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
    localparam logic [5:0] CMD_APP_OP     = 6'd41;
    localparam logic [5:0] CMD_APP_CMD    = 6'd55;

    localparam logic [7:0] BYTE_IDLE     = 8'hFF;
    localparam logic [7:0] START_BITS    = 8'h40;
    localparam logic [7:0] CRC_GO_IDLE   = 8'h95;
    localparam logic [7:0] CRC_SEND_IF   = 8'h87;
    localparam logic [7:0] REPLY_CLEARED = 8'h00;

    localparam logic [2:0] COUNT_CRC  = 3'd5;
    localparam logic [2:0] COUNT_DONE = 3'd6;

    typedef struct packed {
        logic        operation;
        logic [5:0]  command_index;
        logic        app_command;
        logic [31:0] argument;
        logic [7:0]  received_byte;
    } in_item_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] transmit_byte;
        logic       card_selected;
        logic       finished;
        logic [7:0] reply_byte;
    } out_item_t;

endpackage

// ===== hw/rtl/sdspi_fsm.sv =====
// Command sequencer: holds the command state and forms the result of one item.
// Depends on sdspi_pkg for the item types and the command and byte constants.
module sdspi_fsm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  sdspi_pkg::in_item_t  item,
    output sdspi_pkg::out_item_t result
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEADH = 3'd1,
        PH_LEADL = 3'd2,
        PH_FRAME = 3'd3,
        PH_WAIT  = 3'd4,
        PH_TRAIL = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  byte_count_reg, byte_count_next;
    logic [5:0]  held_index_reg, held_index_next;
    logic        prefix_pending_reg, prefix_pending_next;
    logic        held_app_reg, held_app_next;
    logic [31:0] held_argument_reg, held_argument_next;
    logic [7:0]  held_reply_reg, held_reply_next;
    logic        select_reg, select_next;

    logic [5:0]  cur_index;
    logic [31:0] cur_arg;
    logic [7:0]  arg_byte;
    logic [7:0]  crc_byte;
    logic        needs_deselect;
    logic        do_complete;
    logic [7:0]  complete_reply;
    logic        send;
    logic [7:0]  tx;
    logic        fin;
    logic [7:0]  reply;

    assign cur_index = prefix_pending_reg ? sdspi_pkg::CMD_APP_CMD : held_index_reg;
    assign cur_arg   = prefix_pending_reg ? 32'd0 : held_argument_reg;

    always_comb begin
        case (byte_count_reg)
            3'd1:    arg_byte = cur_arg[31:24];
            3'd2:    arg_byte = cur_arg[23:16];
            3'd3:    arg_byte = cur_arg[15:8];
            default: arg_byte = cur_arg[7:0];
        endcase
    end

    always_comb begin
        if (cur_index == sdspi_pkg::CMD_GO_IDLE) begin
            crc_byte = sdspi_pkg::CRC_GO_IDLE;
        end else if (cur_index == sdspi_pkg::CMD_SEND_IF) begin
            crc_byte = sdspi_pkg::CRC_SEND_IF;
        end else begin
            crc_byte = sdspi_pkg::BYTE_IDLE;
        end
    end

    assign needs_deselect = (cur_index inside {sdspi_pkg::CMD_GO_IDLE, sdspi_pkg::CMD_SEND_OP,
                                               sdspi_pkg::CMD_SET_BLKLEN,
                                               sdspi_pkg::CMD_APP_CMD})
                            || ((cur_index == sdspi_pkg::CMD_APP_OP) && held_app_reg
                                && !prefix_pending_reg);

    always_comb begin
        phase_next          = phase_reg;
        byte_count_next     = byte_count_reg;
        held_index_next     = held_index_reg;
        prefix_pending_next = prefix_pending_reg;
        held_app_next       = held_app_reg;
        held_argument_next  = held_argument_reg;
        held_reply_next     = held_reply_reg;
        select_next         = select_reg;
        do_complete         = 1'b0;
        complete_reply      = held_reply_reg;
        send                = 1'b0;
        tx                  = sdspi_pkg::BYTE_IDLE;
        fin                 = 1'b0;
        reply               = sdspi_pkg::REPLY_CLEARED;

        if (item.operation == sdspi_pkg::OP_START) begin
            held_index_next     = item.command_index;
            held_app_next       = item.app_command;
            held_argument_next  = item.argument;
            prefix_pending_next = item.app_command;
            byte_count_next     = 3'd0;
            phase_next          = PH_LEADH;
            select_next         = 1'b0;
            send                = 1'b1;
        end else begin
            case (phase_reg)
                PH_LEADH: begin
                    phase_next  = PH_LEADL;
                    select_next = 1'b1;
                    send        = 1'b1;
                end
                PH_LEADL: begin
                    phase_next      = PH_FRAME;
                    byte_count_next = 3'd1;
                    tx              = sdspi_pkg::START_BITS | {2'b00, cur_index};
                    send            = 1'b1;
                end
                PH_FRAME: begin
                    send = 1'b1;
                    if (byte_count_reg < sdspi_pkg::COUNT_CRC) begin
                        tx              = arg_byte;
                        byte_count_next = byte_count_reg + 3'd1;
                    end else if (byte_count_reg == sdspi_pkg::COUNT_CRC) begin
                        tx              = crc_byte;
                        byte_count_next = sdspi_pkg::COUNT_DONE;
                    end else begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (item.received_byte[7]) begin
                        send = 1'b1;
                    end else begin
                        held_reply_next = item.received_byte;
                        if (needs_deselect) begin
                            phase_next  = PH_TRAIL;
                            select_next = 1'b0;
                            send        = 1'b1;
                        end else begin
                            do_complete    = 1'b1;
                            complete_reply = item.received_byte;
                        end
                    end
                end
                PH_TRAIL: begin
                    do_complete    = 1'b1;
                    complete_reply = held_reply_reg;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (do_complete) begin
            prefix_pending_next = 1'b0;
            if (prefix_pending_reg && (complete_reply <= 8'd1)) begin
                phase_next  = PH_LEADH;
                select_next = 1'b0;
                send        = 1'b1;
            end else begin
                phase_next = PH_IDLE;
                fin        = 1'b1;
                reply      = complete_reply;
            end
        end

        result.send_valid    = send;
        result.transmit_byte = tx;
        result.card_selected = select_next;
        result.finished      = fin;
        result.reply_byte    = reply;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_IDLE;
            byte_count_reg     <= 3'd0;
            held_index_reg     <= 6'd0;
            prefix_pending_reg <= 1'b0;
            held_app_reg       <= 1'b0;
            held_argument_reg  <= 32'd0;
            held_reply_reg     <= sdspi_pkg::BYTE_IDLE;
            select_reg         <= 1'b0;
        end else if (step) begin
            phase_reg          <= phase_next;
            byte_count_reg     <= byte_count_next;
            held_index_reg     <= held_index_next;
            prefix_pending_reg <= prefix_pending_next;
            held_app_reg       <= held_app_next;
            held_argument_reg  <= held_argument_next;
            held_reply_reg     <= held_reply_next;
            select_reg         <= select_next;
        end
    end

endmodule

// ===== hw/rtl/sd_spi_command_transactor.sv =====
// Top level of the SD card SPI-mode command transactor: input register,
// command sequencer and result register. Depends on sdspi_pkg and sdspi_fsm.
//
//  Channel  Direction  Handshake           Payload
//  s_       in         s_valid / s_ready   operation, command_index, app_command,
//                                          argument, received_byte
//  m_       out        m_valid / m_ready   send_valid, transmit_byte, card_selected,
//                                          finished, reply_byte
//
// One item is taken every cycle while m_ready is high; each item gives one result,
// held in the input register and then in the result register. The sequencer step
// between them sets that rate. Reset clears the command state to idle with the card
// deselected. When m_ready is low the result register holds and the input register
// fills, after which s_ready drops until the result is taken.
module sd_spi_command_transactor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [5:0]  s_command_index,
    input  logic        s_app_command,
    input  logic [31:0] s_argument,
    input  logic [7:0]  s_received_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_send_valid,
    output logic [7:0]  m_transmit_byte,
    output logic        m_card_selected,
    output logic        m_finished,
    output logic [7:0]  m_reply_byte
);

    logic                 in_valid_reg;
    sdspi_pkg::in_item_t  in_item_reg;
    logic                 out_valid_reg;
    sdspi_pkg::out_item_t out_item_reg;
    sdspi_pkg::out_item_t result;
    logic                 advance;
    logic                 step;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.operation     <= s_operation;
            in_item_reg.command_index <= s_command_index;
            in_item_reg.app_command   <= s_app_command;
            in_item_reg.argument      <= s_argument;
            in_item_reg.received_byte <= s_received_byte;
        end
    end

    sdspi_fsm u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_item_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_send_valid    = out_item_reg.send_valid;
    assign m_transmit_byte = out_item_reg.transmit_byte;
    assign m_card_selected = out_item_reg.card_selected;
    assign m_finished      = out_item_reg.finished;
    assign m_reply_byte    = out_item_reg.reply_byte;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for sd_spi_command_transactor: drives command starts and byte exchanges,
// and checks each result against a fixed plan row or an in-bench model of the command
// sequencer. Depends on sdspi_pkg and the sd_spi_command_transactor RTL.
module tb;

    typedef enum logic [2:0] {
        CS_IDLE, CS_LEAD_HIGH, CS_LEAD_LOW, CS_FRAME, CS_REPLY_WAIT, CS_TRAIL
    } cmd_phase_t;

    typedef struct packed {
        sdspi_pkg::in_item_t  stim;
        logic                 typed;
        sdspi_pkg::out_item_t want;
    } plan_row_t;

    localparam int                   PHASE_ITEMS = 200;
    localparam int                   LONG_HOLD   = 48;
    localparam sdspi_pkg::out_item_t NO_FIXED    = '0;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic        s_operation     = sdspi_pkg::OP_EXCHANGE;
    logic [5:0]  s_command_index = 6'd0;
    logic        s_app_command   = 1'b0;
    logic [31:0] s_argument      = 32'd0;
    logic [7:0]  s_received_byte = 8'd0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_send_valid;
    logic [7:0]  m_transmit_byte;
    logic        m_card_selected;
    logic        m_finished;
    logic [7:0]  m_reply_byte;

    cmd_phase_t  cmd_phase     = CS_IDLE;
    logic [2:0]  frame_count   = 3'd0;
    logic [5:0]  held_cmd      = 6'd0;
    logic        held_app_flag = 1'b0;
    logic        prefix_due    = 1'b0;
    logic [31:0] held_arg      = 32'd0;
    logic [7:0]  saved_reply   = sdspi_pkg::BYTE_IDLE;
    logic        cs_low        = 1'b0;

    sdspi_pkg::out_item_t pending_results[$];
    logic                 row_typed     = 1'b0;
    sdspi_pkg::out_item_t row_want      = '0;
    int          src_idle_pct  = 0;
    int          sink_stall_pct = 0;
    logic        long_hold_req = 1'b0;
    int          hold_left     = 0;
    int          failures      = 0;
    int          results_seen  = 0;
    int          commands_started = 0;
    int          commands_done = 0;
    int          random_items  = 0;

    sd_spi_command_transactor DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_command_index (s_command_index),
        .s_app_command   (s_app_command),
        .s_argument      (s_argument),
        .s_received_byte (s_received_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_send_valid    (m_send_valid),
        .m_transmit_byte (m_transmit_byte),
        .m_card_selected (m_card_selected),
        .m_finished      (m_finished),
        .m_reply_byte    (m_reply_byte)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic sdspi_pkg::out_item_t advance_command(input sdspi_pkg::in_item_t it);
        sdspi_pkg::out_item_t r;
        logic [5:0]  idx;
        logic [31:0] arg;
        logic        ending;
        logic [7:0]  end_reply;
        r = '{send_valid: 1'b1, transmit_byte: sdspi_pkg::BYTE_IDLE, card_selected: 1'b0,
              finished: 1'b0, reply_byte: sdspi_pkg::REPLY_CLEARED};
        idx = prefix_due ? sdspi_pkg::CMD_APP_CMD : held_cmd;
        arg = prefix_due ? 32'd0 : held_arg;
        ending = 1'b0;
        end_reply = sdspi_pkg::REPLY_CLEARED;
        if (it.operation == sdspi_pkg::OP_START) begin
            held_cmd = it.command_index;
            held_app_flag = it.app_command;
            held_arg = it.argument;
            prefix_due = it.app_command;
            frame_count = 3'd0;
            cmd_phase = CS_LEAD_HIGH;
            cs_low = 1'b0;
        end else begin
            case (cmd_phase)
                CS_LEAD_HIGH: begin
                    cmd_phase = CS_LEAD_LOW;
                    cs_low = 1'b1;
                end
                CS_LEAD_LOW: begin
                    cmd_phase = CS_FRAME;
                    frame_count = 3'd1;
                    r.transmit_byte = sdspi_pkg::START_BITS | {2'b00, idx};
                end
                CS_FRAME: begin
                    if (frame_count < sdspi_pkg::COUNT_CRC) begin
                        r.transmit_byte = arg[8 * (4 - int'(frame_count)) +: 8];
                        frame_count = frame_count + 3'd1;
                    end else if (frame_count == sdspi_pkg::COUNT_CRC) begin
                        r.transmit_byte = (idx == sdspi_pkg::CMD_GO_IDLE) ?
                                          sdspi_pkg::CRC_GO_IDLE :
                                          (idx == sdspi_pkg::CMD_SEND_IF) ?
                                          sdspi_pkg::CRC_SEND_IF : sdspi_pkg::BYTE_IDLE;
                        frame_count = sdspi_pkg::COUNT_DONE;
                    end else begin
                        cmd_phase = CS_REPLY_WAIT;
                    end
                end
                CS_REPLY_WAIT: begin
                    if (!it.received_byte[7]) begin
                        saved_reply = it.received_byte;
                        if (idx == sdspi_pkg::CMD_GO_IDLE || idx == sdspi_pkg::CMD_SEND_OP ||
                            idx == sdspi_pkg::CMD_SET_BLKLEN ||
                            idx == sdspi_pkg::CMD_APP_CMD ||
                            (idx == sdspi_pkg::CMD_APP_OP && held_app_flag &&
                             !prefix_due)) begin
                            cmd_phase = CS_TRAIL;
                            cs_low = 1'b0;
                        end else begin
                            ending = 1'b1;
                            end_reply = it.received_byte;
                        end
                    end
                end
                CS_TRAIL: begin
                    ending = 1'b1;
                    end_reply = saved_reply;
                end
                default: begin
                    cmd_phase = CS_IDLE;
                    r.send_valid = 1'b0;
                end
            endcase
        end
        // A good CMD55 reply (0x00 or 0x01) moves on to the real command, from its lead-in bytes.
        if (ending) begin
            if (prefix_due && end_reply <= 8'd1) begin
                prefix_due = 1'b0;
                cmd_phase = CS_LEAD_HIGH;
                cs_low = 1'b0;
            end else begin
                prefix_due = 1'b0;
                cmd_phase = CS_IDLE;
                r.send_valid = 1'b0;
                r.finished = 1'b1;
                r.reply_byte = end_reply;
            end
        end
        r.card_selected = cs_low;
        return r;
    endfunction

    function automatic sdspi_pkg::in_item_t start_item(input logic [5:0] idx, input logic app,
                                                       input logic [31:0] arg);
        return '{sdspi_pkg::OP_START, idx, app, arg, 8'h00};
    endfunction

    function automatic sdspi_pkg::in_item_t exchange_item(input logic [7:0] rx);
        return '{sdspi_pkg::OP_EXCHANGE, 6'd0, 1'b0, 32'd0, rx};
    endfunction

    function automatic sdspi_pkg::out_item_t outcome(input logic sv, input logic [7:0] tx,
                                                     input logic sel, input logic fin,
                                                     input logic [7:0] reply);
        return '{sv, tx, sel, fin, reply};
    endfunction

    function automatic sdspi_pkg::in_item_t random_start();
        sdspi_pkg::in_item_t it;
        it.operation = sdspi_pkg::OP_START;
        case ($urandom_range(9))
            0: it.command_index = sdspi_pkg::CMD_GO_IDLE;
            1: it.command_index = sdspi_pkg::CMD_SEND_OP;
            2: it.command_index = sdspi_pkg::CMD_SEND_IF;
            3: it.command_index = sdspi_pkg::CMD_SET_BLKLEN;
            4: it.command_index = sdspi_pkg::CMD_APP_OP;
            5: it.command_index = sdspi_pkg::CMD_APP_CMD;
            default: it.command_index = 6'($urandom_range(63));
        endcase
        it.app_command = ($urandom_range(99) < 40);
        it.argument = $urandom;
        it.received_byte = 8'($urandom);
        return it;
    endfunction

    function automatic logic [7:0] card_byte();
        if (cmd_phase != CS_REPLY_WAIT) return 8'($urandom);
        if ($urandom_range(99) < 55) return {1'b1, 7'($urandom)};
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'h01;
            default: return {1'b0, 7'($urandom)};
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input sdspi_pkg::in_item_t it, input logic typed,
                             input sdspi_pkg::out_item_t want);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= it.operation;
        s_command_index <= it.command_index;
        s_app_command <= it.app_command;
        s_argument <= it.argument;
        s_received_byte <= it.received_byte;
        row_typed = typed;
        row_want = want;
        if (it.operation == sdspi_pkg::OP_START) commands_started++;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic random_command();
        send_item(random_start(), 1'b0, NO_FIXED);
        random_items++;
        while (cmd_phase != CS_IDLE) begin
            if ($urandom_range(99) < 2) begin
                send_item(random_start(), 1'b0, NO_FIXED);
            end else begin
                send_item(exchange_item(card_byte()), 1'b0, NO_FIXED);
            end
            random_items++;
        end
    endtask

    always @(negedge aclk) begin
        if (long_hold_req) begin
            hold_left = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        sdspi_pkg::out_item_t got;
        sdspi_pkg::out_item_t want;
        sdspi_pkg::in_item_t  taken;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_send_valid, m_transmit_byte, m_card_selected, m_finished, m_reply_byte};
                results_seen++;
                if (got.finished) commands_done++;
                if (pending_results.size() == 0) begin
                    $error("result with no item outstanding: %h", got);
                    failures++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.send_valid !== want.send_valid) begin
                        $error("send_valid: expected %0h, got %0h", want.send_valid,
                               got.send_valid);
                        failures++;
                    end
                    if (got.transmit_byte !== want.transmit_byte) begin
                        $error("transmit_byte: expected %02h, got %02h", want.transmit_byte,
                               got.transmit_byte);
                        failures++;
                    end
                    if (got.card_selected !== want.card_selected) begin
                        $error("card_selected: expected %0h, got %0h", want.card_selected,
                               got.card_selected);
                        failures++;
                    end
                    if (got.finished !== want.finished) begin
                        $error("finished: expected %0h, got %0h", want.finished, got.finished);
                        failures++;
                    end
                    if (got.reply_byte !== want.reply_byte) begin
                        $error("reply_byte: expected %02h, got %02h", want.reply_byte,
                               got.reply_byte);
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                taken = '{s_operation, s_command_index, s_app_command, s_argument,
                          s_received_byte};
                want = advance_command(taken);
                pending_results.push_back(row_typed ? row_want : want);
            end
        end
    end

    initial begin
        plan_row_t plan [26];
        logic      hold_done;
        hold_done = 1'b0;
        plan = '{
            '{exchange_item(8'hFF), 1'b1,
              outcome(1'b0, sdspi_pkg::BYTE_IDLE, 1'b0, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{start_item(sdspi_pkg::CMD_GO_IDLE, 1'b0, 32'h0000_0000), 1'b1,
              outcome(1'b1, sdspi_pkg::BYTE_IDLE, 1'b0, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'h00), 1'b1,
              outcome(1'b1, sdspi_pkg::BYTE_IDLE, 1'b1, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'h00), 1'b1,
              outcome(1'b1, sdspi_pkg::START_BITS, 1'b1, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'hFF), 1'b1,
              outcome(1'b1, 8'h00, 1'b1, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'h7F), 1'b0, NO_FIXED},
            '{exchange_item(8'h80), 1'b0, NO_FIXED},
            '{exchange_item(8'h00), 1'b0, NO_FIXED},
            '{exchange_item(8'h00), 1'b1,
              outcome(1'b1, sdspi_pkg::CRC_GO_IDLE, 1'b1, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'hFF), 1'b0, NO_FIXED},
            '{exchange_item(8'hFF), 1'b0, NO_FIXED},
            '{exchange_item(8'h01), 1'b0, NO_FIXED},
            '{exchange_item(8'hFF), 1'b1,
              outcome(1'b0, sdspi_pkg::BYTE_IDLE, 1'b0, 1'b1, 8'h01)},
            '{start_item(sdspi_pkg::CMD_SEND_IF, 1'b1, 32'hFFFF_FFFF), 1'b1,
              outcome(1'b1, sdspi_pkg::BYTE_IDLE, 1'b0, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'h55), 1'b0, NO_FIXED},
            '{exchange_item(8'hAA), 1'b1,
              outcome(1'b1, 8'h77, 1'b1, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{start_item(6'd63, 1'b0, 32'h8000_0001), 1'b1,
              outcome(1'b1, sdspi_pkg::BYTE_IDLE, 1'b0, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'h00), 1'b0, NO_FIXED},
            '{exchange_item(8'h00), 1'b1,
              outcome(1'b1, 8'h7F, 1'b1, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'h00), 1'b1,
              outcome(1'b1, 8'h80, 1'b1, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'h00), 1'b0, NO_FIXED},
            '{exchange_item(8'h00), 1'b0, NO_FIXED},
            '{exchange_item(8'h00), 1'b0, NO_FIXED},
            '{exchange_item(8'h00), 1'b1,
              outcome(1'b1, sdspi_pkg::BYTE_IDLE, 1'b1, 1'b0, sdspi_pkg::REPLY_CLEARED)},
            '{exchange_item(8'h00), 1'b0, NO_FIXED},
            '{exchange_item(8'h00), 1'b1,
              outcome(1'b0, sdspi_pkg::BYTE_IDLE, 1'b1, 1'b1, 8'h00)}
        };
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (plan[i]) send_item(plan[i].stim, plan[i].typed, plan[i].want);
        for (int p = 0; p < 4; p++) begin
            src_idle_pct = (p == 1) ? 63 : (p == 3) ? 33 : 0;
            sink_stall_pct = (p == 2) ? 63 : (p == 3) ? 33 : 0;
            while (random_items < PHASE_ITEMS * (p + 1)) begin
                if ($urandom_range(99) < 10) begin
                    repeat ($urandom_range(3, 1)) begin
                        send_item(exchange_item(8'($urandom)), 1'b0, NO_FIXED);
                    end
                end
                random_command();
                if (p == 0 && !hold_done && random_items >= PHASE_ITEMS / 2) begin
                    long_hold_req = 1'b1;
                    hold_done = 1'b1;
                end
            end
            s_valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge aclk);
        end
        repeat (20) @(negedge aclk);
        $display("Covered %0d command starts (%0d completed) in %0d checked results,",
                 commands_started, commands_done, results_seen);
        $display("under free-running, sender-idle, receiver-stall and mixed pacing.");
        if (failures == 0) begin
            $display("sd_spi_command_transactor test passed");
        end else begin
            $display("sd_spi_command_transactor test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("sd_spi_command_transactor test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/sdspi_pkg.sv
hw/rtl/sdspi_fsm.sv
hw/rtl/sd_spi_command_transactor.sv
sim/tb.sv
